FILE: sv/lcdne_pkg.sv
// lcdne_pkg: shared types, codes and the glyph table for the lcd character nibble encoder
// no dependencies; imported by lcdne_encode and lcd_character_nibble_encoder
package lcdne_pkg;

   localparam int CodeWidth = 8;
   localparam int AddrWidth = 7;
   localparam int NibbleWidth = 4;
   localparam int CsrIndexWidth = 1;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_SECOND_LINE_BASE = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_THIRD_LINE_BASE = 1'd1;

   localparam logic [AddrWidth-1:0] SECOND_LINE_BASE_RESET = 7'd64;
   localparam logic [AddrWidth-1:0] THIRD_LINE_BASE_RESET = 7'd20;

   // control character codes
   localparam logic [CodeWidth-1:0] CHR_BELL = 8'h07;
   localparam logic [CodeWidth-1:0] CHR_BACKSPACE = 8'h08;
   localparam logic [CodeWidth-1:0] CHR_NEWLINE = 8'h0A;
   localparam logic [CodeWidth-1:0] CHR_FORM_FEED = 8'h0C;

   // display commands
   localparam logic [CodeWidth-1:0] CMD_SET_DDRAM = 8'h80;
   localparam logic [CodeWidth-1:0] CMD_CLEAR = 8'h01;
   localparam logic [CodeWidth-1:0] CMD_CURSOR_LEFT = 8'h10;

   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA = 1'b1;

   // cyrillic glyphs for codes 0xc0-0xff
   localparam logic [CodeWidth-1:0] CYR_GLYPH [0:63] = '{
      8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
      8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
      8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
      8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'hAD, 8'hAF, 8'hB0, 8'hB1,
      8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
      8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
      8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
      8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
   };

   typedef struct packed {
      logic [CodeWidth-1:0] data_byte;
      logic register_select;
   } enc_type;

endpackage

FILE: sv/lcdne_encode.sv
// lcdne_encode: maps one character code to a display byte and register-select bit
// depends on lcdne_pkg
module lcdne_encode (
   input  logic [lcdne_pkg::CodeWidth-1:0] code,
   input  logic [lcdne_pkg::AddrWidth-1:0] second_line_base,
   input  logic [lcdne_pkg::AddrWidth-1:0] third_line_base,
   output lcdne_pkg::enc_type              enc
);
   import lcdne_pkg::*;

   always_comb begin
      enc.register_select = RS_COMMAND;
      enc.data_byte = code;
      unique case (code)
         CHR_BELL: begin
            enc.data_byte = CMD_SET_DDRAM | {1'b0, second_line_base};
         end
         CHR_BACKSPACE: begin
            enc.data_byte = CMD_CURSOR_LEFT;
         end
         CHR_NEWLINE: begin
            enc.data_byte = CMD_SET_DDRAM | {1'b0, third_line_base};
         end
         CHR_FORM_FEED: begin
            enc.data_byte = CMD_CLEAR;
         end
         default: begin
            enc.register_select = RS_DATA;
            if (code[7:6] == 2'b11) begin
               enc.data_byte = CYR_GLYPH[code[5:0]];
            end else begin
               enc.data_byte = code;
            end
         end
      endcase
   end

endmodule

FILE: sv/lcd_character_nibble_encoder.sv
// lcd_character_nibble_encoder: top level, character item in, two nibble items out
// depends on lcdne_pkg and lcdne_encode
//
// Each accepted character becomes one display byte sent as two result items: the high
// nibble, then the low nibble with rsp_last_nibble set; both carry the same register
// select. A character is held in the input register and is encoded into the result register,
// which shows the high nibble first. The result register sends one nibble per cycle while
// rsp_stall is low; the input register can take the next character as the high nibble is
// loaded, and holds it while the low nibble goes out.
module lcd_character_nibble_encoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lcdne_pkg::CodeWidth-1:0]    req_char_code,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lcdne_pkg::NibbleWidth-1:0]  rsp_bus_nibble,
   output logic                               rsp_register_select,
   output logic                               rsp_last_nibble,
   input  logic                               csr_write,
   input  logic [lcdne_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [lcdne_pkg::AddrWidth-1:0]    csr_wdata
);
   import lcdne_pkg::*;

   logic [AddrWidth-1:0]   second_base_ff, second_base_in;
   logic [AddrWidth-1:0]   third_base_ff, third_base_in;
   logic                   in_valid_ff, in_valid_in;
   logic [CodeWidth-1:0]   in_code_ff, in_code_in;
   logic                   out_valid_ff, out_valid_in;
   logic [NibbleWidth-1:0] out_nibble_ff, out_nibble_in;
   logic                   out_rs_ff, out_rs_in;
   logic                   out_last_ff, out_last_in;
   logic                   low_pend_ff, low_pend_in;
   logic [NibbleWidth-1:0] low_nibble_ff, low_nibble_in;
   enc_type                enc;
   logic                   out_free;
   logic                   in_take;

   lcdne_encode u_encode (
      .code             (in_code_ff),
      .second_line_base (second_base_ff),
      .third_line_base  (third_base_ff),
      .enc              (enc)
   );

   always_comb begin
      second_base_in = second_base_ff;
      third_base_in = third_base_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SECOND_LINE_BASE: second_base_in = csr_wdata;
            CSR_THIRD_LINE_BASE:  third_base_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      out_free = !out_valid_ff || !rsp_stall;
      in_take = 1'b0;
      out_valid_in = out_valid_ff;
      out_nibble_in = out_nibble_ff;
      out_rs_in = out_rs_ff;
      out_last_in = out_last_ff;
      low_pend_in = low_pend_ff;
      low_nibble_in = low_nibble_ff;
      if (out_free) begin
         if (low_pend_ff) begin
            out_valid_in = 1'b1;
            out_nibble_in = low_nibble_ff;
            out_last_in = 1'b1;
            low_pend_in = 1'b0;
         end else if (in_valid_ff) begin
            in_take = 1'b1;
            out_valid_in = 1'b1;
            out_nibble_in = enc.data_byte[7:4];
            out_rs_in = enc.register_select;
            out_last_in = 1'b0;
            low_pend_in = 1'b1;
            low_nibble_in = enc.data_byte[3:0];
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   assign req_stall = in_valid_ff && !in_take;

   always_comb begin
      in_valid_in = in_valid_ff && !in_take;
      in_code_in = in_code_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_code_in = req_char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_base_ff <= SECOND_LINE_BASE_RESET;
         third_base_ff <= THIRD_LINE_BASE_RESET;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         low_pend_ff <= 1'b0;
      end else begin
         second_base_ff <= second_base_in;
         third_base_ff <= third_base_in;
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         low_pend_ff <= low_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      in_code_ff <= in_code_in;
      out_nibble_ff <= out_nibble_in;
      out_rs_ff <= out_rs_in;
      out_last_ff <= out_last_in;
      low_nibble_ff <= low_nibble_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_bus_nibble = out_nibble_ff;
   assign rsp_register_select = out_rs_ff;
   assign rsp_last_nibble = out_last_ff;

   // a pending low nibble means its high nibble is on the output
   assert property (@(posedge clock) disable iff (reset)
      low_pend_ff |-> (out_valid_ff && !out_last_ff))
      else $error("low nibble pending without high nibble shown");

   // high nibble taken is followed at once by the low nibble with the same select
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_nibble) |=>
         (rsp_valid && rsp_last_nibble
          && rsp_register_select == $past(rsp_register_select)))
      else $error("low nibble did not follow high nibble");

   // the input register is not drained while a low nibble is still owed
   assert property (@(posedge clock) disable iff (reset)
      low_pend_ff |-> !in_take)
      else $error("item taken before low nibble sent");

endmodule
